// File: design/vma_pkg.sv
// Shared types, widths and helpers for the vector moving average block.
package vma_pkg;

    localparam int MAX_WINDOW  = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int AXES        = 3;
    localparam int SLOT_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int CFG_W       = 5;
    localparam int SUM_W       = SAMPLE_BITS + SLOT_W;
    localparam int NUM_W       = SUM_W + 1;
    localparam int DEN_W       = CNT_W + 1;
    localparam int ITER_W      = $clog2(NUM_W);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_x;
        logic signed [SAMPLE_BITS-1:0] sample_y;
        logic signed [SAMPLE_BITS-1:0] sample_z;
    } t_sample;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mean_x;
        logic signed [SAMPLE_BITS-1:0] mean_y;
        logic signed [SAMPLE_BITS-1:0] mean_z;
    } t_mean;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [SUM_W-1:0] sum_z;
        logic [CNT_W-1:0]        count;
    } t_div_req;

    function automatic logic signed [SUM_W-1:0] sext_sum(
        input logic signed [SAMPLE_BITS-1:0] v
    );
        return {{(SUM_W - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
    endfunction

endpackage

// File: design/vector_moving_average_core.sv
// Top level of the three-axis boxcar moving average.
//
//  channel  | signals                         | direction
//  ---------+---------------------------------+----------
//  input    | i_in_valid, o_in_stall, i_in    | in
//  output   | o_out_valid, i_out_stall, o_out | out
//  config   | i_cfg_wr_en, i_cfg_wr_data      | in
//
// Input is stalled from accept until the result load: one history RAM read, one sum update
// and write-back, 21 divider steps, one result load; no new item is taken before then.
// Synchronous active-low reset clears sums, count, ring position and sets window to 1.
// A result held by output stall keeps the next result in the divider and the input stalled.
module vector_moving_average_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [vma_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  vma_pkg::t_sample          i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output vma_pkg::t_mean            o_out
);

    import vma_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_UPD,
        S_DIV
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_window, n_window;
    logic [CNT_W-1:0]        r_held, n_held;
    logic [SLOT_W-1:0]       r_wslot, n_wslot;
    logic signed [SUM_W-1:0] r_sum_x, n_sum_x;
    logic signed [SUM_W-1:0] r_sum_y, n_sum_y;
    logic signed [SUM_W-1:0] r_sum_z, n_sum_z;
    logic                    r_out_valid, n_out_valid;
    t_mean                   r_out, n_out;
    t_sample                 r_sample;
    logic [SLOT_W-1:0]       r_slot;
    logic                    r_full;

    logic                    w_in_acc;
    logic                    w_out_free;
    logic [SLOT_W-1:0]       w_slot_cur;
    logic                    w_full;
    t_sample                 w_old;
    logic [CFG_W-1:0]        w_rd_unused;
    logic [SAMPLE_BITS*AXES-1:0] w_rd_data;
    logic signed [SUM_W-1:0] w_upd_x, w_upd_y, w_upd_z;
    logic [CNT_W-1:0]        w_upd_held;
    logic [CNT_W-1:0]        w_slot_inc;
    logic [SLOT_W-1:0]       w_upd_wslot;
    logic [CNT_W-1:0]        w_cfg_window;
    t_div_req                w_req;
    logic                    w_div_done;
    t_mean                   w_div_mean;

    assign w_rd_unused = '0;
    assign o_in_stall  = (r_state != S_IDLE) || (w_rd_unused != '0);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_slot_cur = ({1'b0, r_wslot} >= r_window) ? '0 : r_wslot;
    assign w_full     = r_held >= r_window;

    assign w_old   = t_sample'(w_rd_data);
    assign w_upd_x = r_sum_x - (r_full ? sext_sum(w_old.sample_x) : '0)
                     + sext_sum(r_sample.sample_x);
    assign w_upd_y = r_sum_y - (r_full ? sext_sum(w_old.sample_y) : '0)
                     + sext_sum(r_sample.sample_y);
    assign w_upd_z = r_sum_z - (r_full ? sext_sum(w_old.sample_z) : '0)
                     + sext_sum(r_sample.sample_z);
    assign w_upd_held  = r_full ? r_held : r_held + 1'b1;
    assign w_slot_inc  = {1'b0, r_slot} + 1'b1;
    assign w_upd_wslot = (w_slot_inc >= r_window) ? '0 : w_slot_inc[SLOT_W-1:0];

    always_comb begin
        if (i_cfg_wr_data == '0) begin
            w_cfg_window = CNT_W'(1);
        end else if (CNT_W'(i_cfg_wr_data) > CNT_W'(MAX_WINDOW)) begin
            w_cfg_window = CNT_W'(MAX_WINDOW);
        end else begin
            w_cfg_window = CNT_W'(i_cfg_wr_data);
        end
    end

    assign w_req.start = (r_state == S_UPD);
    assign w_req.sum_x = w_upd_x;
    assign w_req.sum_y = w_upd_y;
    assign w_req.sum_z = w_upd_z;
    assign w_req.count = w_upd_held;

    vma_ring_ram #(
        .DEPTH (MAX_WINDOW),
        .WIDTH ($bits(t_sample))
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_UPD),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_re    (r_state == S_READ),
        .i_raddr (r_slot),
        .o_rdata (w_rd_data)
    );

    vma_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_div_done),
        .o_mean  (w_div_mean)
    );

    always_comb begin
        n_state     = r_state;
        n_window    = r_window;
        n_held      = r_held;
        n_wslot     = r_wslot;
        n_sum_x     = r_sum_x;
        n_sum_y     = r_sum_y;
        n_sum_z     = r_sum_z;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_sum_x = w_upd_x;
                n_sum_y = w_upd_y;
                n_sum_z = w_upd_z;
                n_held  = w_upd_held;
                n_wslot = w_upd_wslot;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done || r_out_valid == 1'b0 || !i_out_stall) begin
                    if (w_div_done && w_out_free) begin
                        n_out       = w_div_mean;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_wr_en) begin
            n_window = w_cfg_window;
            n_held   = '0;
            n_wslot  = '0;
            n_sum_x  = '0;
            n_sum_y  = '0;
            n_sum_z  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= CNT_W'(1);
            r_held      <= '0;
            r_wslot     <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_z     <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            r_state     <= n_state;
            r_window    <= n_window;
            r_held      <= n_held;
            r_wslot     <= n_wslot;
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_sum_z     <= n_sum_z;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample <= i_in;
            r_slot   <= w_slot_cur;
            r_full   <= w_full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_held_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= r_window)
        else $error("held count above window length");

    a_wslot_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_wslot} < r_window)
        else $error("ring position outside window");

    a_done_clears_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD |=> !w_div_done)
        else $error("divider result flag not cleared by start");

    a_result_has_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && w_div_done && w_out_free) |=> (o_out_valid && r_held != '0))
        else $error("result loaded with no samples held");

    a_accept_reads_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_READ && {1'b0, r_slot} < r_window))
        else $error("accepted beat did not start a ring read");
`endif

endmodule

// File: design/vma_ring_ram.sv
// Single-port-write, registered-read RAM holding the sample history ring.
module vma_ring_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/vma_divider.sv
// Three-lane bit-serial restoring divider producing rounded means.
module vma_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vma_pkg::t_div_req i_req,
    output logic              o_done,
    output vma_pkg::t_mean    o_mean
);

    import vma_pkg::*;

    logic [NUM_W-1:0]  r_num [AXES];
    logic [DEN_W-1:0]  r_rem [AXES];
    logic              r_neg [AXES];
    logic [DEN_W-1:0]  r_den;
    logic [ITER_W-1:0] r_iter;
    logic              r_busy;
    logic              r_done;

    logic signed [SUM_W-1:0]  w_sum   [AXES];
    logic [SUM_W-1:0]         w_mag   [AXES];
    logic [NUM_W-1:0]         w_num0  [AXES];
    logic [DEN_W:0]           w_trial [AXES];
    logic                     w_ge    [AXES];
    logic [NUM_W-1:0]         n_num   [AXES];
    logic [DEN_W-1:0]         n_rem   [AXES];
    logic [SAMPLE_BITS-1:0]   w_q     [AXES];
    logic [SAMPLE_BITS-1:0]   w_mean  [AXES];

    assign w_sum[0] = i_req.sum_x;
    assign w_sum[1] = i_req.sum_y;
    assign w_sum[2] = i_req.sum_z;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_mag[a]   = w_sum[a][SUM_W-1] ? SUM_W'(-w_sum[a]) : SUM_W'(w_sum[a]);
            w_num0[a]  = {w_mag[a], 1'b0} + NUM_W'(i_req.count);
            w_trial[a] = {r_rem[a], r_num[a][NUM_W-1]};
            w_ge[a]    = w_trial[a] >= {1'b0, r_den};
            n_rem[a]   = w_ge[a] ? DEN_W'(w_trial[a] - {1'b0, r_den})
                                 : DEN_W'(w_trial[a]);
            n_num[a]   = {r_num[a][NUM_W-2:0], w_ge[a]};
            w_q[a]     = r_num[a][SAMPLE_BITS-1:0];
            w_mean[a]  = r_neg[a] ? SAMPLE_BITS'(-w_q[a]) : w_q[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_iter <= '0;
            end else if (r_busy) begin
                if (r_iter == ITER_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_iter <= r_iter + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= {i_req.count, 1'b0};
            for (int a = 0; a < AXES; a++) begin
                r_num[a] <= w_num0[a];
                r_rem[a] <= '0;
                r_neg[a] <= w_sum[a][SUM_W-1];
            end
        end else if (r_busy) begin
            for (int a = 0; a < AXES; a++) begin
                r_num[a] <= n_num[a];
                r_rem[a] <= n_rem[a];
            end
        end
    end

    assign o_done        = r_done;
    assign o_mean.mean_x = w_mean[0];
    assign o_mean.mean_y = w_mean[1];
    assign o_mean.mean_z = w_mean[2];

endmodule

// File: verif/vector_moving_average_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for vector_moving_average_core: directed table, then random windows.
module vector_moving_average_core_tb;
    import vma_pkg::*;

    localparam int GAP_PCT      = 21;
    localparam int RANDOM_ITEMS = 1225;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 60;

    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_BITS-1:0] S_NEG = 16'shffff;

    typedef enum bit {ROW_SAMPLE, ROW_WINDOW} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [CFG_W-1:0] window;
        t_sample          smp;
        logic [4:0]       reps;
        bit               has_fixed;
        t_mean            fixed_mean;
    } t_script_row;

    localparam int SCRIPT_ROWS = 15;
    localparam t_script_row SCRIPT [SCRIPT_ROWS] = '{
        '{ROW_SAMPLE, 5'd0, {16'sd100, -16'sd200, 16'sd300}, 5'd1, 1'b1,
          {16'sd100, -16'sd200, 16'sd300}},
        '{ROW_SAMPLE, 5'd0, {S_MIN, S_MAX, 16'sd0}, 5'd1, 1'b1, {S_MIN, S_MAX, 16'sd0}},
        '{ROW_SAMPLE, 5'd0, {S_MAX, S_MIN, S_NEG}, 5'd1, 1'b1, {S_MAX, S_MIN, S_NEG}},
        // zero window acts as one
        '{ROW_WINDOW, 5'd0, '0, 5'd0, 1'b0, '0},
        '{ROW_SAMPLE, 5'd0, {16'sd5, -16'sd5, 16'sd1}, 5'd1, 1'b1, {16'sd5, -16'sd5, 16'sd1}},
        '{ROW_WINDOW, 5'd2, '0, 5'd0, 1'b0, '0},
        '{ROW_SAMPLE, 5'd0, {16'sd1, -16'sd1, 16'sd0}, 5'd1, 1'b1, {16'sd1, -16'sd1, 16'sd0}},
        // half-way means round away from zero
        '{ROW_SAMPLE, 5'd0, {16'sd2, -16'sd2, 16'sd0}, 5'd1, 1'b1, {16'sd2, -16'sd2, 16'sd0}},
        '{ROW_SAMPLE, 5'd0, {16'sd3, -16'sd3, 16'sd7}, 5'd1, 1'b0, '0},
        // saturate to the deepest window, fill it with extremes, then wrap
        '{ROW_WINDOW, 5'd17, '0, 5'd0, 1'b0, '0},
        '{ROW_SAMPLE, 5'd0, {S_MIN, S_MAX, S_MIN}, 5'd1, 1'b1, {S_MIN, S_MAX, S_MIN}},
        '{ROW_SAMPLE, 5'd0, {S_MAX, S_MIN, S_MAX}, 5'd15, 1'b0, '0},
        '{ROW_SAMPLE, 5'd0, {S_MIN, S_MAX, 16'sd0}, 5'd1, 1'b0, '0},
        '{ROW_WINDOW, 5'd31, '0, 5'd0, 1'b0, '0},
        '{ROW_SAMPLE, 5'd0, {-16'sd3, 16'sd3, S_NEG}, 5'd1, 1'b1, {-16'sd3, 16'sd3, S_NEG}}
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    t_sample              in_bus    = '0;
    logic                 out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_mean                o_out;

    bit                   steady = 1'b0;
    int                   fail_count = 0;
    int                   quiet_cycles = 0;
    t_mean                pending_means [$];

    logic signed [SAMPLE_BITS-1:0] hist [MAX_WINDOW][AXES];
    longint               acc [AXES];
    int                   held;
    int                   wr_pos;
    int                   win_len;

    vector_moving_average_core uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_in          (in_bus),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_out         (o_out)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void restart_window(input logic [CFG_W-1:0] w);
        win_len = (w == 0) ? 1 : (w > MAX_WINDOW) ? MAX_WINDOW : int'(w);
        held = 0;
        wr_pos = 0;
        foreach (acc[a]) acc[a] = 0;
    endfunction

    function automatic longint rounded_mean(input longint s, input int n);
        if (s >= 0) return (2 * s + n) / (2 * n);
        return -((-2 * s + n) / (2 * n));
    endfunction

    function automatic t_mean advance_window(input t_sample smp);
        logic signed [SAMPLE_BITS-1:0] v [AXES];
        logic signed [SAMPLE_BITS-1:0] m [AXES];
        t_mean r;
        bit full;
        int pos;
        v[0] = smp.sample_x;
        v[1] = smp.sample_y;
        v[2] = smp.sample_z;
        pos = (wr_pos >= win_len) ? 0 : wr_pos;
        full = held >= win_len;
        for (int a = 0; a < AXES; a++) begin
            if (full) acc[a] -= hist[pos][a];
            hist[pos][a] = v[a];
            acc[a] += v[a];
        end
        if (!full) held++;
        wr_pos = (pos + 1 >= win_len) ? 0 : pos + 1;
        for (int a = 0; a < AXES; a++) m[a] = SAMPLE_BITS'(rounded_mean(acc[a], held));
        r.mean_x = m[0];
        r.mean_y = m[1];
        r.mean_z = m[2];
        return r;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_axis();
        int v;
        case ($urandom_range(0, 9))
            0: v = int'(S_MIN);
            1: v = int'(S_MAX);
            2, 3, 4: v = int'($urandom_range(0, 1023)) - 512;
            default: v = $urandom;
        endcase
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic t_sample random_sample();
        t_sample s;
        s.sample_x = random_axis();
        s.sample_y = random_axis();
        s.sample_z = random_axis();
        return s;
    endfunction

    task automatic push_sample(input t_sample smp, input bit has_fixed, input t_mean fixed_mean);
        t_mean model_mean;
        while (!steady && $urandom_range(0, 99) < GAP_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_bus <= smp;
        do @(posedge clk); while (o_in_stall);
        model_mean = advance_window(smp);
        if (has_fixed) model_mean = fixed_mean;
        pending_means.insert(pending_means.size(), model_mean);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] w);
        in_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_data <= w;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        restart_window(w);
    endtask

    task automatic check_axis(input string name, input logic signed [SAMPLE_BITS-1:0] want,
                              input logic signed [SAMPLE_BITS-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    initial begin
        forever begin
            @(posedge clk);
            out_stall <= !steady && ($urandom_range(0, 99) < GAP_PCT);
        end
    end

    always @(posedge clk) begin
        t_mean want;
        bit took_in;
        bit took_out;
        if (rst_n) begin
            took_in = in_valid && !o_in_stall;
            took_out = o_out_valid && !out_stall;
            if (took_out) begin
                if (pending_means.size() == 0) begin
                    $error("unexpected beat: mean_x %0d mean_y %0d mean_z %0d",
                           o_out.mean_x, o_out.mean_y, o_out.mean_z);
                    fail_count++;
                end else begin
                    want = pending_means.pop_front();
                    check_axis("mean_x", want.mean_x, o_out.mean_x);
                    check_axis("mean_y", want.mean_y, o_out.mean_y);
                    check_axis("mean_z", want.mean_z, o_out.mean_z);
                end
            end
            quiet_cycles = (took_in || took_out) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("vector_moving_average_core regression: fail");
                $finish;
            end
        end
    end

    initial begin
        int total;
        int phase;
        int n;
        logic [CFG_W-1:0] w;
        total = 0;
        phase = 0;
        restart_window(5'd1);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < SCRIPT_ROWS; r++) begin
            if (SCRIPT[r].kind == ROW_WINDOW) begin
                write_window(SCRIPT[r].window);
            end else begin
                repeat (SCRIPT[r].reps)
                    push_sample(SCRIPT[r].smp, SCRIPT[r].has_fixed, SCRIPT[r].fixed_mean);
            end
        end

        while (total < RANDOM_ITEMS) begin
            case (phase)
                0: w = CFG_W'(MAX_WINDOW);
                1: w = 5'd1;
                2: w = 5'd0;
                3: w = 5'd31;
                default: w = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 31))
                                                         : CFG_W'($urandom_range(1, MAX_WINDOW));
            endcase
            write_window(w);
            n = (w <= 1) ? $urandom_range(10, 40) : $urandom_range(40, 160);
            repeat (n) begin
                steady = (total >= 500 && total < 800);
                push_sample(random_sample(), 1'b0, '0);
                total++;
            end
            phase++;
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("vector_moving_average_core regression: pass");
        end else begin
            $display("vector_moving_average_core regression: fail");
        end
        $finish;
    end

endmodule
